[rtl/core/kpvf_pkg.sv]
// ----------------------------------------------------------------------------
// kpvf_pkg
// Shared types and constants of the position/velocity filter core.
// ----------------------------------------------------------------------------
package kpvf_pkg;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 24;

  localparam logic [CfgIndexWidth-1:0] RegNoisePos  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegNoiseVel  = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegNoiseMeas = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegGravity   = 2'd3;

  localparam logic [23:0] NoisePosReset  = 24'd655;
  localparam logic [23:0] NoiseVelReset  = 24'd197;
  localparam logic [23:0] NoiseMeasReset = 24'd65536;
  localparam logic [19:0] GravityReset   = 20'd642253;

  typedef struct packed {
    logic signed [15:0] accel_g;
    logic signed [31:0] measured_distance;
    logic        [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_estimate;
    logic signed [31:0] velocity_estimate;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_M2, S_C1, S_VP, S_C2, S_C4, S_C3, S_PRED, S_DEN,
    S_DIV0, S_DIV0W, S_DIV1, S_DIV1W, S_K1,
    S_NV, S_N00, S_N01, S_N10, S_N11U, S_FIN, S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[rtl/core/kpvf_stream_if.sv]
// ----------------------------------------------------------------------------
// kpvf_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface kpvf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/kpvf_divider.sv]
// ----------------------------------------------------------------------------
// kpvf_divider
// Radix-2 restoring divider, signed quotient truncated toward zero.
// ----------------------------------------------------------------------------
module kpvf_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  num,
  input  logic        [32:0]  den,
  output logic                busy,
  output logic signed [31:0]  quot
);

  // numerator magnitude is |num|<<16, 48 bits
  logic [47:0] q;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        neg;
  logic [32:0] dreg;
  logic [33:0] trial;
  logic [48:0] qs;

  assign trial = {rem[32:0], q[47]} - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd48;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[31];
      q    <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial;
        q   <= {q[46:0], 1'b1};
      end else begin
        rem <= {rem[32:0], q[47]};
        q   <= {q[46:0], 1'b0};
      end
    end
  end

  assign qs   = neg ? -{1'b0, q} : {1'b0, q};
  assign quot = kpvf_pkg::sat32(66'(signed'(qs)));

endmodule

[rtl/core/kalman_position_velocity_filter_core.sv]
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter_core
// Two-state position/velocity filter, one shared 36x32 multiplier.
// each step runs the shared multiplier states, then two 48-step divisions
// for the gain, skipped when the gain denominator is not positive
// not ready while a step runs, so one transaction is taken at a time; a
// result waiting in the output register holds the step
// rst clears state, covariance and config registers to their defaults
// ----------------------------------------------------------------------------
module kalman_position_velocity_filter_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [kpvf_pkg::CfgIndexWidth-1:0]      cfg_index,
  input  logic [kpvf_pkg::CfgDataWidth-1:0]       cfg_data,
  kpvf_stream_if.sink                             in_ch,
  kpvf_stream_if.source                           out_ch
);

  logic [23:0] noise_pos, noise_vel, noise_meas;
  logic [19:0] gravity;

  kpvf_pkg::state_t state, state_next;

  logic signed [31:0] position, velocity, p00, p01, p10, p11;
  logic signed [31:0] pp, vv, n00, n01, n10, n11, k0, k1, e, d11;
  logic signed [31:0] meas_dist, dt_s;
  logic signed [15:0] acc;
  logic        [15:0] dt;
  logic signed [32:0] t;
  logic signed [32:0] den;
  logic               den_pos;
  logic signed [35:0] ma;
  logic signed [31:0] mb;
  logic signed [65:0] prod, prod_r;
  logic               out_valid, out_free;
  kpvf_pkg::out_item_t out_r;

  logic               div_start, div_busy;
  logic signed [31:0] dnum, quot;

  // round to nearest, ties up, >>16
  function automatic logic signed [65:0] rs16(input logic signed [65:0] v);
    logic signed [65:0] b;
    b = v + 66'sd32768;
    return b >>> 16;
  endfunction

  assign prod     = 66'(ma) * 66'(mb);
  assign dt_s     = {16'd0, dt};
  assign den_pos  = !den[32] && (den != '0);
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_pos  <= kpvf_pkg::NoisePosReset;
      noise_vel  <= kpvf_pkg::NoiseVelReset;
      noise_meas <= kpvf_pkg::NoiseMeasReset;
      gravity    <= kpvf_pkg::GravityReset;
    end else if (cfg_we) begin
      case (cfg_index)
        kpvf_pkg::RegNoisePos:  noise_pos  <= cfg_data;
        kpvf_pkg::RegNoiseVel:  noise_vel  <= cfg_data;
        kpvf_pkg::RegNoiseMeas: noise_meas <= cfg_data;
        kpvf_pkg::RegGravity:   gravity    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready  = (state == kpvf_pkg::S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_r;

  kpvf_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (den),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= kpvf_pkg::S_IDLE;
    else     state <= state_next;
  end

  // operand select and sequencing
  always_comb begin
    state_next = state;
    ma         = '0;
    mb         = '0;
    div_start  = 1'b0;
    dnum       = n00;
    case (state)
      kpvf_pkg::S_IDLE: begin
        if (in_ch.valid) state_next = kpvf_pkg::S_M1;
      end
      kpvf_pkg::S_M1: begin
        ma = 36'(signed'({1'b0, gravity}));
        mb = 32'(acc);
        state_next = kpvf_pkg::S_M2;
      end
      kpvf_pkg::S_M2: begin
        ma = prod_r[35:0];
        mb = dt_s;
        state_next = kpvf_pkg::S_C1;
      end
      kpvf_pkg::S_C1: begin
        ma = 36'(p11);
        mb = dt_s;
        state_next = kpvf_pkg::S_VP;
      end
      kpvf_pkg::S_VP: begin
        ma = 36'(vv);
        mb = dt_s;
        state_next = kpvf_pkg::S_C2;
      end
      kpvf_pkg::S_C2: begin
        ma = 36'(p01) + 36'(d11);
        mb = dt_s;
        state_next = kpvf_pkg::S_C4;
      end
      kpvf_pkg::S_C4: begin
        ma = 36'(signed'({1'b0, noise_vel}));
        mb = dt_s;
        state_next = kpvf_pkg::S_C3;
      end
      kpvf_pkg::S_C3: begin
        ma = 36'(p10) + 36'(t) + 36'(signed'({1'b0, noise_pos}));
        mb = dt_s;
        state_next = kpvf_pkg::S_PRED;
      end
      kpvf_pkg::S_PRED: state_next = kpvf_pkg::S_DEN;
      kpvf_pkg::S_DEN:  state_next = kpvf_pkg::S_DIV0;
      kpvf_pkg::S_DIV0: begin
        if (!den_pos) begin
          state_next = kpvf_pkg::S_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = kpvf_pkg::S_DIV0W;
        end
      end
      kpvf_pkg::S_DIV0W: begin
        if (!div_busy) state_next = kpvf_pkg::S_DIV1;
      end
      kpvf_pkg::S_DIV1: begin
        dnum       = n10;
        div_start  = 1'b1;
        state_next = kpvf_pkg::S_DIV1W;
      end
      kpvf_pkg::S_DIV1W: begin
        if (!div_busy) state_next = kpvf_pkg::S_K1;
      end
      kpvf_pkg::S_K1: begin
        ma = 36'(k0);
        mb = e;
        state_next = kpvf_pkg::S_NV;
      end
      kpvf_pkg::S_NV: begin
        ma = 36'(k1);
        mb = e;
        state_next = kpvf_pkg::S_N00;
      end
      kpvf_pkg::S_N00: begin
        ma = 36'(n00);
        mb = k0;
        state_next = kpvf_pkg::S_N01;
      end
      kpvf_pkg::S_N01: begin
        ma = 36'(n01);
        mb = k0;
        state_next = kpvf_pkg::S_N10;
      end
      kpvf_pkg::S_N10: begin
        ma = 36'(k1);
        mb = n00;
        state_next = kpvf_pkg::S_N11U;
      end
      kpvf_pkg::S_N11U: begin
        ma = 36'(k1);
        mb = n01;
        state_next = kpvf_pkg::S_FIN;
      end
      kpvf_pkg::S_FIN: state_next = kpvf_pkg::S_OUT;
      kpvf_pkg::S_OUT: begin
        if (out_free) state_next = kpvf_pkg::S_IDLE;
      end
      default: state_next = kpvf_pkg::S_IDLE;
    endcase
  end

  // each state that uses a product takes the one registered by the state before
  always_ff @(posedge clk) begin
    prod_r <= prod;
    case (state)
      kpvf_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          acc       <= in_ch.data.accel_g;
          meas_dist <= in_ch.data.measured_distance;
          dt        <= in_ch.data.time_step;
        end
      end
      kpvf_pkg::S_C1: vv <= kpvf_pkg::sat32(66'(velocity) +
                                           ((prod_r + 66'sd134217728) >>> 28));
      kpvf_pkg::S_VP: d11 <= 32'(rs16(prod_r));
      kpvf_pkg::S_C2: begin
        pp  <= kpvf_pkg::sat32(66'(position) + rs16(prod_r));
        n01 <= kpvf_pkg::sat32(66'(p01) + 66'(d11));
        n10 <= kpvf_pkg::sat32(66'(p10) + 66'(d11));
      end
      kpvf_pkg::S_C4: t <= 33'(rs16(prod_r));
      kpvf_pkg::S_C3: n11 <= kpvf_pkg::sat32(66'(p11) + rs16(prod_r));
      kpvf_pkg::S_PRED: begin
        n00 <= kpvf_pkg::sat32(66'(p00) + rs16(prod_r));
        e   <= kpvf_pkg::sat32(66'(meas_dist) - 66'(pp));
      end
      kpvf_pkg::S_DEN: den <= 33'(n00) + 33'(signed'({1'b0, noise_meas}));
      kpvf_pkg::S_DIV1: k0 <= quot;
      kpvf_pkg::S_K1:   k1 <= quot;
      kpvf_pkg::S_NV:   pp <= kpvf_pkg::sat32(66'(pp) + rs16(prod_r));
      kpvf_pkg::S_N00:  vv <= kpvf_pkg::sat32(66'(vv) + rs16(prod_r));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      velocity  <= '0;
      p00       <= '0;
      p01       <= '0;
      p10       <= '0;
      p11       <= '0;
      out_valid <= 1'b0;
      out_r     <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        kpvf_pkg::S_DIV0: begin
          if (!den_pos) begin
            p00 <= n00;
            p01 <= n01;
            p10 <= n10;
            p11 <= n11;
          end
        end
        kpvf_pkg::S_N01:  p00 <= kpvf_pkg::sat32(66'(n00) - rs16(prod_r));
        kpvf_pkg::S_N10:  p01 <= kpvf_pkg::sat32(66'(n01) - rs16(prod_r));
        kpvf_pkg::S_N11U: p10 <= kpvf_pkg::sat32(66'(n10) - rs16(prod_r));
        kpvf_pkg::S_FIN:  p11 <= kpvf_pkg::sat32(66'(n11) - rs16(prod_r));
        kpvf_pkg::S_OUT: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_r.position_estimate <= pp;
            out_r.velocity_estimate <= vv;
            position                <= pp;
            velocity                <= vv;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != kpvf_pkg::S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_after_step: assert property (@(posedge clk) disable iff (rst)
    (state == kpvf_pkg::S_OUT && out_free) |=> out_valid) else $error("result lost");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(out_r)))
    else $error("waiting result changed");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted");

endmodule

[dv/kpvf_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpvf_tb_if
// Testbench-side note: the channel interface comes from the RTL; this file
// holds the sample-side helper types used by the filter testbench.
// ----------------------------------------------------------------------------
package kpvf_tb_pkg;

  typedef struct {
    kpvf_pkg::in_item_t  item;
    bit                  has_expect;
    kpvf_pkg::out_item_t expect_out;
  } stim_row_t;

endpackage

[dv/kalman_position_velocity_filter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter_core_tb
// Self-checking testbench for the position/velocity filter core. A directed
// table and random traffic drive the input channel with random gaps and
// output stalls; a fixed-point predictor computes each filtered position and
// velocity, and results are compared field by field in order.
// ----------------------------------------------------------------------------
module kalman_position_velocity_filter_core_tb;

  localparam int NumRandom = 2000;
  localparam int Latency   = 200;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [kpvf_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [kpvf_pkg::CfgDataWidth-1:0]  cfg_data;

  kpvf_stream_if #(.payload_t(kpvf_pkg::in_item_t))  in_ch ();
  kpvf_stream_if #(.payload_t(kpvf_pkg::out_item_t)) out_ch ();

  kalman_position_velocity_filter_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor state
  longint unsigned q_pos_noise, q_vel_noise, r_noise, grav;
  longint est_pos, est_vel;
  longint cov [4];

  kpvf_pkg::out_item_t filtered_q[$];
  int errors;
  bit stall_free;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint b;
    b = v + (longint'(1) << (s - 1));
    return b >>> s;
  endfunction

  function automatic kpvf_pkg::out_item_t filter_step(kpvf_pkg::in_item_t it);
    longint acc, meas, dt, p, v, p00, p01, p10, p11, t, den, k0, k1, e;
    longint n00, n01, n10, n11, d11;
    kpvf_pkg::out_item_t r;
    acc = longint'(it.accel_g);
    meas = longint'(it.measured_distance);
    dt = longint'({48'd0, it.time_step});
    v = clip32(est_vel + round_shift(longint'(grav) * acc * dt, 28));
    p = clip32(est_pos + round_shift(v * dt, 16));
    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    t = round_shift(dt * p11, 16);
    t = round_shift(dt * (p01 + t), 16);
    t = round_shift(dt * (p10 + t + longint'(q_pos_noise)), 16);
    d11 = round_shift(dt * p11, 16);
    n00 = clip32(p00 + t);
    n01 = clip32(p01 + d11);
    n10 = clip32(p10 + d11);
    n11 = clip32(p11 + round_shift(dt * longint'(q_vel_noise), 16));
    p00 = n00; p01 = n01; p10 = n10; p11 = n11;
    den = p00 + longint'(r_noise);
    if (den > 0) begin
      k0 = clip32((p00 * 65536) / den);
      k1 = clip32((p10 * 65536) / den);
      e = clip32(meas - p);
      p = clip32(p + round_shift(k0 * e, 16));
      v = clip32(v + round_shift(k1 * e, 16));
      n00 = clip32(p00 - round_shift(p00 * k0, 16));
      n01 = clip32(p01 - round_shift(p01 * k0, 16));
      n10 = clip32(p10 - round_shift(k1 * p00, 16));
      n11 = clip32(p11 - round_shift(k1 * p01, 16));
      p00 = n00; p01 = n01; p10 = n10; p11 = n11;
    end
    est_pos = p; est_vel = v;
    cov[0] = p00; cov[1] = p01; cov[2] = p10; cov[3] = p11;
    r.position_estimate = p[31:0];
    r.velocity_estimate = v[31:0];
    return r;
  endfunction

  function automatic int gap_len();
    if (stall_free) return 0;
    if ($urandom_range(0, 19) == 0) return int'($urandom_range(10, 60));
    if ($urandom_range(0, 1) == 0) return 0;
    return int'($urandom_range(1, 3));
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output side with random stalls
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      n = gap_len();
      if (n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (filtered_q.size() == 0) begin
        $display("%t: unexpected transaction, actual %h", $time, out_ch.data);
        errors++;
      end else begin
        kpvf_pkg::out_item_t x;
        x = filtered_q.pop_front();
        if (x.position_estimate !== out_ch.data.position_estimate) begin
          $display("%t: position expected %0d actual %0d", $time,
                   x.position_estimate, out_ch.data.position_estimate);
          errors++;
        end
        if (x.velocity_estimate !== out_ch.data.velocity_estimate) begin
          $display("%t: velocity expected %0d actual %0d", $time,
                   x.velocity_estimate, out_ch.data.velocity_estimate);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [kpvf_pkg::CfgIndexWidth-1:0] idx,
                           longint unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[kpvf_pkg::CfgDataWidth-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      kpvf_pkg::RegNoisePos:  q_pos_noise = val & 24'hffffff;
      kpvf_pkg::RegNoiseVel:  q_vel_noise = val & 24'hffffff;
      kpvf_pkg::RegNoiseMeas: r_noise = val & 24'hffffff;
      kpvf_pkg::RegGravity:   grav = val & 20'hfffff;
      default: ;
    endcase
  endtask

  task automatic send(kpvf_pkg::in_item_t it, bit has_expect,
                      kpvf_pkg::out_item_t want);
    int n;
    kpvf_pkg::out_item_t pr;
    n = gap_len();
    repeat (n + 1) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    pr = filter_step(it);
    if (has_expect && pr !== want) begin
      $display("%t: table row expected %h predictor %h", $time, want, pr);
      errors++;
    end
    filtered_q.push_back(pr);
  endtask

  task automatic drain();
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  function automatic kpvf_pkg::in_item_t rand_item(bit extreme);
    kpvf_pkg::in_item_t it;
    it.accel_g = 16'($urandom);
    it.measured_distance = extreme ? 32'($urandom) :
                           32'(int'($urandom_range(0, 4000000)) - 2000000);
    it.time_step = 16'(extreme ? $urandom : $urandom_range(0, 1500));
    return it;
  endfunction

  kpvf_tb_pkg::stim_row_t table_rows [$];

  initial begin
    kpvf_tb_pkg::stim_row_t row;
    kpvf_pkg::in_item_t it;
    kpvf_pkg::out_item_t none;
    none = '0;
    errors = 0;
    stall_free = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    q_pos_noise = kpvf_pkg::NoisePosReset; q_vel_noise = kpvf_pkg::NoiseVelReset;
    r_noise = kpvf_pkg::NoiseMeasReset; grav = kpvf_pkg::GravityReset;
    est_pos = 0; est_vel = 0;
    foreach (cov[i]) cov[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset, zero dt and zero distance leaves everything at zero
    row.item = '{16'sd0, 32'sd0, 16'd0}; row.has_expect = 1; row.expect_out = '0;
    table_rows.push_back(row);
    row.has_expect = 0;
    row.item = '{16'sh7fff, 32'sh7fffffff, 16'hffff}; table_rows.push_back(row);
    row.item = '{16'sh8000, 32'sh80000000, 16'hffff}; table_rows.push_back(row);
    row.item = '{16'sh7fff, 32'sh80000000, 16'hffff}; table_rows.push_back(row);
    row.item = '{16'sh8000, 32'sh7fffffff, 16'd0}; table_rows.push_back(row);
    row.item = '{16'sd4096, 32'sd65536, 16'd655}; table_rows.push_back(row);
    row.item = '{-16'sd4096, -32'sd65536, 16'd1}; table_rows.push_back(row);
    row.item = '{16'sd0, 32'sd0, 16'd0}; table_rows.push_back(row);
    foreach (table_rows[i])
      send(table_rows[i].item, table_rows[i].has_expect, table_rows[i].expect_out);
    drain();

    // extremes of configuration, including non-positive gain denominator
    write_reg(kpvf_pkg::RegNoiseMeas, 1);
    write_reg(kpvf_pkg::RegNoisePos, 24'hffffff);
    write_reg(kpvf_pkg::RegNoiseVel, 24'hffffff);
    write_reg(kpvf_pkg::RegGravity, 20'hfffff);
    for (int i = 0; i < 12; i++) begin
      it = rand_item(1);
      send(it, 0, none);
    end
    drain();
    write_reg(kpvf_pkg::RegNoiseMeas, 24'hffffff);
    write_reg(kpvf_pkg::RegNoisePos, 0);
    write_reg(kpvf_pkg::RegNoiseVel, 0);
    write_reg(kpvf_pkg::RegGravity, 0);
    for (int i = 0; i < 10; i++) send(rand_item(1), 0, none);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(kpvf_pkg::RegNoisePos,
                (ph == 0) ? kpvf_pkg::NoisePosReset : $urandom_range(0, 5000));
      write_reg(kpvf_pkg::RegNoiseVel,
                (ph == 0) ? kpvf_pkg::NoiseVelReset : $urandom_range(0, 5000));
      write_reg(kpvf_pkg::RegNoiseMeas,
                (ph == 0) ? kpvf_pkg::NoiseMeasReset : $urandom_range(1, 24'hffffff));
      write_reg(kpvf_pkg::RegGravity,
                (ph == 0) ? kpvf_pkg::GravityReset : $urandom_range(0, 20'hfffff));
      stall_free = (ph == 2);
      for (int i = 0; i < NumRandom / 4; i++) begin
        send(rand_item($urandom_range(0, 9) == 0), 0, none);
        if (i == 100) begin
          while (filtered_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
